// File: rtl/adc_frame_to_batch_packetizer_macros.svh
// Assertion macros used by the checker file of the packetizer.
`ifndef ADC_FRAME_TO_BATCH_PACKETIZER_MACROS_SVH
`define ADC_FRAME_TO_BATCH_PACKETIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AFB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define AFB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/afb_pkg.sv
package afb_pkg;

    // Fixed frame and header geometry.
    localparam int STATUS_BYTES = 3;
    localparam int POS_W        = 5;
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 16;
    localparam int GAIN_W       = 5;
    localparam int NUM_GAINS    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int HCNT_W       = 3;
    localparam int Q_DEPTH      = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN0 = 2'd0,
        CFG_GAIN1 = 2'd1,
        CFG_GAIN2 = 2'd2,
        CFG_GAIN3 = 2'd3
    } t_cfg_idx;

    // Header byte positions; HDR_DONE means the header has gone out.
    typedef enum logic [HCNT_W-1:0] {
        HDR_IDX_LO = 3'd0,
        HDR_IDX_HI = 3'd1,
        HDR_GAIN0  = 3'd2,
        HDR_GAIN1  = 3'd3,
        HDR_GAIN2  = 3'd4,
        HDR_GAIN3  = 3'd5,
        HDR_DONE   = 3'd6
    } t_hdr_pos;

    typedef logic [NUM_GAINS-1:0][GAIN_W-1:0] t_gains;

    // One classified channel byte on its way to the back end.
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic              hdr;
        logic              pend;
        logic [BYTE_W-1:0] data;
    } t_q_entry;

endpackage

// File: rtl/afb_frame_if.sv
interface afb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;

    modport source (output valid, output frame_byte, output frame_start, input ready);
    modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// File: rtl/afb_packet_if.sv
interface afb_packet_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       packet_end;
    logic       run_end;

    modport source (output valid, output packet_byte, output packet_end, output run_end,
                    input ready);
    modport sink   (input valid, input packet_byte, input packet_end, input run_end,
                    output ready);
endinterface

// File: rtl/afb_front.sv
module afb_front
    import afb_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int BATCH_FRAMES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afb_frame_if.sink   i_frame,
    input  logic        i_full,
    output logic        o_push,
    output t_q_entry    o_entry
);

    localparam int FRAME_BYTES = STATUS_BYTES + 3 * CHANNELS;
    localparam int FIB_W       = (BATCH_FRAMES > 1) ? $clog2(BATCH_FRAMES) : 1;
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] FIRST_CH   = POS_W'(STATUS_BYTES);
    localparam logic [POS_W-1:0] FRAME_LEN  = POS_W'(FRAME_BYTES);
    localparam logic [FIB_W-1:0] LAST_FRAME = FIB_W'(BATCH_FRAMES - 1);
    localparam logic [IDX_W-1:0] IDX_STEP   = IDX_W'(BATCH_FRAMES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [FIB_W-1:0] r_fib, n_fib;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [POS_W-1:0] pos;
    logic             accept, last_in_frame, last_in_batch;

    assign i_frame.ready = !i_full;
    assign accept        = i_frame.valid && !i_full;

    // Position of this beat in its frame; a frame start restarts at zero.
    always_comb begin
        pos = i_frame.frame_start ? '0 : r_pos;
        if (pos >= FRAME_LEN) begin
            pos = '0;
        end
    end

    assign last_in_frame = (pos == LAST_POS);
    assign last_in_batch = last_in_frame && (r_fib >= LAST_FRAME);

    // Channel beats go to the queue; the first one of a batch carries the header.
    assign o_push        = accept && (pos >= FIRST_CH);
    assign o_entry.data  = i_frame.frame_byte;
    assign o_entry.pend  = last_in_batch;
    assign o_entry.hdr   = (pos == FIRST_CH) && (r_fib == '0);
    assign o_entry.index = r_idx;

    // Frame and batch bookkeeping.
    always_comb begin
        n_pos = r_pos;
        n_fib = r_fib;
        n_idx = r_idx;
        if (accept) begin
            n_pos = last_in_frame ? '0 : pos + POS_W'(1);
            if (last_in_batch) begin
                n_fib = '0;
                n_idx = r_idx + IDX_STEP;
            end else if (last_in_frame) begin
                n_fib = r_fib + FIB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_fib <= '0;
            r_idx <= '0;
        end else begin
            r_pos <= n_pos;
            r_fib <= n_fib;
            r_idx <= n_idx;
        end
    end

endmodule

// File: rtl/afb_queue.sv
module afb_queue
    import afb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_q_entry o_entry
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

    t_q_entry          r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Occupancy count.
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= PTR_W'((32'(r_wr) + 1) % Q_DEPTH);
            end
            if (do_pop) begin
                r_rd <= PTR_W'((32'(r_rd) + 1) % Q_DEPTH);
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// File: rtl/afb_back.sv
module afb_back
    import afb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_q_entry     i_q_entry,
    output logic         o_pop,
    input  t_gains       i_gains,
    afb_packet_if.source o_packet
);

    logic [HCNT_W-1:0] r_hcnt, n_hcnt;
    logic              r_ov;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_pend, n_pend;
    logic              r_run, n_run;
    logic              load;

    assign load = i_q_valid && (!r_ov || o_packet.ready);

    // Expand a header entry into six header beats before its channel beat.
    always_comb begin
        n_hcnt = r_hcnt;
        n_byte = i_q_entry.data;
        n_pend = i_q_entry.pend;
        n_run  = 1'b1;
        o_pop  = 1'b0;
        if (i_q_entry.hdr && (r_hcnt != HDR_DONE)) begin
            n_pend = 1'b0;
            n_run  = 1'b0;
            case (r_hcnt)
                HDR_IDX_LO: n_byte = i_q_entry.index[BYTE_W-1:0];
                HDR_IDX_HI: n_byte = i_q_entry.index[IDX_W-1:BYTE_W];
                HDR_GAIN0:  n_byte = BYTE_W'(i_gains[0]);
                HDR_GAIN1:  n_byte = BYTE_W'(i_gains[1]);
                HDR_GAIN2:  n_byte = BYTE_W'(i_gains[2]);
                HDR_GAIN3:  n_byte = BYTE_W'(i_gains[3]);
                default:    n_byte = i_q_entry.data;
            endcase
            if (load) begin
                n_hcnt = r_hcnt + HCNT_W'(1);
            end
        end else if (load) begin
            o_pop  = 1'b1;
            n_hcnt = HDR_IDX_LO;
        end
    end

    // Output register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_hcnt <= HDR_IDX_LO;
        end else begin
            r_hcnt <= n_hcnt;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_packet.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_pend <= n_pend;
            r_run  <= n_run;
        end
    end

    assign o_packet.valid       = r_ov;
    assign o_packet.packet_byte = r_byte;
    assign o_packet.packet_end  = r_pend;
    assign o_packet.run_end     = r_run;

endmodule

// File: rtl/adc_frame_to_batch_packetizer.sv
// A channel beat is written into the queue at the accepting edge and then into the output
// register; a header adds six beats ahead.
// The output passes one beat per cycle while the receiver is ready; while a header
// goes out ahead of its channel beat, the two-entry queue fills and the input stalls.
// Reset is synchronous and active low: position, batch count and index go to
// zero, the gains to 24, and the queue and output register are emptied.
module adc_frame_to_batch_packetizer
    import afb_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int BATCH_FRAMES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    afb_frame_if.sink            i_frame,
    afb_packet_if.source         o_packet,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(24);

    t_gains   r_gains;
    t_q_entry push_entry, q_entry;
    logic     push, full, pop, q_valid;

    // Gain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= {NUM_GAINS{GAIN_RESET}};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN0: r_gains[0] <= i_cfg_data;
                CFG_GAIN1: r_gains[1] <= i_cfg_data;
                CFG_GAIN2: r_gains[2] <= i_cfg_data;
                CFG_GAIN3: r_gains[3] <= i_cfg_data;
                default:   r_gains    <= r_gains;
            endcase
        end
    end

    afb_front #(
        .CHANNELS     (CHANNELS),
        .BATCH_FRAMES (BATCH_FRAMES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (i_frame),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    afb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    afb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .i_gains   (r_gains),
        .o_packet  (o_packet)
    );

endmodule

// File: rtl/afb_chk.sv
`include "adc_frame_to_batch_packetizer_macros.svh"

module afb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_pend,
    input logic       i_out_run
);

    logic [2:0] r_hdr_cnt;
    logic       out_beat;

    assign out_beat = i_out_valid && i_out_ready;

    // Count header beats seen since the last end of run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= '0;
        end else if (out_beat) begin
            r_hdr_cnt <= i_out_run ? 3'd0 : r_hdr_cnt + 3'd1;
        end
    end

    `AFB_ASSERT_NXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_pend) && $stable(i_out_run), "stalled output beat changed")
    `AFB_ASSERT_IMP(a_pend_run, i_out_valid && i_out_pend, i_out_run, "packet end without run end")
    `AFB_ASSERT_IMP(a_hdr_len, out_beat && !i_out_run, r_hdr_cnt < 3'd6, "header longer than six beats")
    `AFB_ASSERT_IMP(a_hdr_full, out_beat && i_out_run, r_hdr_cnt == 3'd0 || r_hdr_cnt == 3'd6, "header cut short")

endmodule

bind adc_frame_to_batch_packetizer afb_chk u_afb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_packet.valid),
    .i_out_ready (o_packet.ready),
    .i_out_byte  (o_packet.packet_byte),
    .i_out_pend  (o_packet.packet_end),
    .i_out_run   (o_packet.run_end)
);

// File: test/tb_adc_frame_to_batch_packetizer.sv
module tb_adc_frame_to_batch_packetizer;
    import afb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS      = 8;
    localparam int BATCH_FRAMES  = 8;
    localparam int FRAME_BYTES   = STATUS_BYTES + 3 * CHANNELS;
    localparam int HEADER_BYTES  = 6;
    localparam int PHASE_ITEMS   = 108;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTED   = 20;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } t_frame_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              pend;
        logic              run_end;
    } t_pkt_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [GAIN_W-1:0]    cfg_data;

    afb_frame_if  frame_ch ();
    afb_packet_if packet_ch ();

    adc_frame_to_batch_packetizer #(
        .CHANNELS     (CHANNELS),
        .BATCH_FRAMES (BATCH_FRAMES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frame_ch),
        .o_packet   (packet_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Frame beats waiting to be offered, and packet beats still owed by the block.
    t_frame_beat frame_backlog[$];
    t_pkt_beat   pkt_expect[$];

    // Private copy of the packetizer state and of the gain registers.
    logic [POS_W-1:0]  frm_pos;
    int                frm_count;
    logic [IDX_W-1:0]  batch_idx;
    logic [GAIN_W-1:0] gain_reg[NUM_GAINS];

    int send_idle_pct;
    int recv_idle_pct;
    int beats_in;
    int beats_out;
    int packets_done;
    int headers_seen;
    int err_count;
    int cycle_count;
    int hold_at;
    int hold_left;
    logic hold_used;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Work out the packet beats that one accepted frame beat gives rise to.
    task automatic packetize_byte(input logic [BYTE_W-1:0] data, input logic start);
        int pos;
        logic last_frm;
        logic last_batch;
        logic [BYTE_W-1:0] hdr[HEADER_BYTES];
        if (start) begin
            frm_pos = '0;
        end
        pos = frm_pos;
        if (pos >= FRAME_BYTES) begin
            pos = 0;
        end
        last_frm = (pos == FRAME_BYTES - 1);
        frm_pos  = last_frm ? '0 : POS_W'(pos + 1);
        // Status bytes are dropped.
        if (pos < STATUS_BYTES) begin
            return;
        end
        // The first channel byte of a batch is preceded by the header.
        if (pos == STATUS_BYTES && frm_count == 0) begin
            hdr[0] = batch_idx[7:0];
            hdr[1] = batch_idx[15:8];
            for (int g = 0; g < NUM_GAINS; g++) begin
                hdr[2 + g] = BYTE_W'(gain_reg[g]);
            end
            for (int k = 0; k < HEADER_BYTES; k++) begin
                pkt_expect.push_back('{data: hdr[k], pend: 1'b0, run_end: 1'b0});
            end
        end
        last_batch = last_frm && (frm_count >= BATCH_FRAMES - 1);
        pkt_expect.push_back('{data: data, pend: last_batch, run_end: 1'b1});
        if (last_batch) begin
            frm_count = 0;
            batch_idx = batch_idx + IDX_W'(BATCH_FRAMES);
        end else if (last_frm) begin
            frm_count++;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
        end
    endtask

    task automatic write_gain(input t_cfg_idx idx, input logic [GAIN_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        gain_reg[idx] = val;
    endtask

    task automatic queue_beat(input logic [BYTE_W-1:0] data, input logic start);
        frame_backlog.push_back('{data: data, start: start});
    endtask

    // Mostly whole frames with random samples; some cut short, some bare noise.
    task automatic queue_random_frames(input int n_items);
        int queued;
        int kind;
        int len;
        logic mark;
        queued = 0;
        while (queued < n_items) begin
            kind = $urandom_range(99);
            if (kind < 78) begin
                len  = FRAME_BYTES;
                mark = ($urandom_range(99) < 85);
                for (int k = 0; k < len; k++) begin
                    queue_beat(BYTE_W'($urandom_range(255)), (k == 0) && mark);
                end
            end else if (kind < 90) begin
                len = $urandom_range(FRAME_BYTES - 1, 1);
                for (int k = 0; k < len; k++) begin
                    queue_beat(BYTE_W'($urandom_range(255)), k == 0);
                end
            end else begin
                len = $urandom_range(8, 1);
                for (int k = 0; k < len; k++) begin
                    queue_beat(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
            queued += len;
        end
    endtask

    // Poll on the falling edge so that every update of the rising edge has settled.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (frame_backlog.size() != 0 || frame_ch.valid || pkt_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Frame side: predict each accepted beat, then offer the next one or idle.
    always @(posedge i_clk) begin : drive_frames
        t_frame_beat nxt;
        if (!i_rst_n) begin
            frame_ch.valid <= 1'b0;
        end else begin
            if (frame_ch.valid && frame_ch.ready) begin
                packetize_byte(frame_ch.frame_byte, frame_ch.frame_start);
                beats_in <= beats_in + 1;
            end
            if (!frame_ch.valid || frame_ch.ready) begin
                if (frame_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = frame_backlog.pop_front();
                    frame_ch.valid       <= 1'b1;
                    frame_ch.frame_byte  <= nxt.data;
                    frame_ch.frame_start <= nxt.start;
                end else begin
                    frame_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Packet side: check each accepted beat against the oldest expectation.
    always @(posedge i_clk) begin : watch_packets
        t_pkt_beat want;
        if (!i_rst_n) begin
            packet_ch.ready <= 1'b0;
        end else begin
            if (packet_ch.valid && packet_ch.ready) begin
                beats_out++;
                if (packet_ch.packet_end) begin
                    packets_done++;
                end
                if (pkt_expect.size() == 0) begin
                    report_mismatch("unexpected beat", packet_ch.packet_byte, 0);
                end else begin
                    want = pkt_expect.pop_front();
                    if (!want.run_end) begin
                        headers_seen++;
                    end
                    if (packet_ch.packet_byte !== want.data) begin
                        report_mismatch("packet_byte", packet_ch.packet_byte, want.data);
                    end
                    if (packet_ch.packet_end !== want.pend) begin
                        report_mismatch("packet_end", packet_ch.packet_end, want.pend);
                    end
                    if (packet_ch.run_end !== want.run_end) begin
                        report_mismatch("run_end", packet_ch.run_end, want.run_end);
                    end
                end
            end
            packet_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One long receiver hold-off, started once the chosen input beat count is reached.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && hold_at != 0 && beats_in >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
                     pkt_expect.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // Known values on every input before the first edge.
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_GAIN0;
        cfg_data             = '0;
        frame_ch.valid       = 1'b0;
        frame_ch.frame_byte  = '0;
        frame_ch.frame_start = 1'b0;
        packet_ch.ready      = 1'b0;
        frm_pos       = '0;
        frm_count     = 0;
        batch_idx     = '0;
        for (int g = 0; g < NUM_GAINS; g++) begin
            gain_reg[g] = GAIN_W'(24);
        end
        beats_in      = 0;
        beats_out     = 0;
        packets_done  = 0;
        headers_seen  = 0;
        err_count     = 0;
        cycle_count   = 0;
        hold_at       = 0;
        send_idle_pct = 28;
        recv_idle_pct = 45;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a first frame cut inside its channel bytes, so that the header
        // goes out twice, then a frame that continues with the reset gains.
        queue_beat(8'hFF, 1'b1);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hA5, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'h80, 1'b0);
        queue_beat(8'h7F, 1'b0);
        queue_beat(8'h55, 1'b0);
        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h12, 1'b0);
        queue_beat(8'hAA, 1'b0);
        queue_beat(8'h01, 1'b0);
        queue_beat(8'hFE, 1'b0);
        queue_beat(8'h80, 1'b0);
        queue_beat(8'h7F, 1'b0);
        // A start mark on a status byte right after another frame start.
        queue_beat(8'h3C, 1'b1);
        queue_beat(8'hC3, 1'b1);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h00, 1'b0);
        wait_idle();

        // Phase one: gains at their limits and outside the nominal range.
        write_gain(CFG_GAIN0, 5'd0);
        write_gain(CFG_GAIN1, 5'd31);
        write_gain(CFG_GAIN2, 5'd1);
        write_gain(CFG_GAIN3, 5'd24);
        queue_random_frames(PHASE_ITEMS);
        wait_idle();

        // Phase two: random gains, idling the other way round.
        send_idle_pct = 45;
        recv_idle_pct = 28;
        write_gain(CFG_GAIN0, GAIN_W'($urandom_range(31)));
        write_gain(CFG_GAIN1, GAIN_W'($urandom_range(31)));
        write_gain(CFG_GAIN2, GAIN_W'($urandom_range(31)));
        write_gain(CFG_GAIN3, GAIN_W'($urandom_range(31)));
        queue_random_frames(PHASE_ITEMS);
        wait_idle();

        // Phase three: no idling, and one long stall of the receiver midway.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_gain(CFG_GAIN0, 5'd31);
        write_gain(CFG_GAIN1, 5'd0);
        write_gain(CFG_GAIN2, 5'd24);
        write_gain(CFG_GAIN3, 5'd1);
        hold_at = beats_in + 40;
        queue_random_frames(PHASE_ITEMS);
        wait_idle();

        if (pkt_expect.size() != 0) begin
            report_mismatch("beats never delivered", 0, pkt_expect.size());
        end
        $display("Sent %0d frame beats and checked %0d packet beats, %0d of them header bytes.",
                 beats_in, beats_out, headers_seen);
        $display("Closed %0d packets over three gain settings; %0d mismatches.",
                 packets_done, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
